// ----- sv/sas_pkg.sv -----
// shared types and constants for the scoped attribute stack
// request and response structs, opcode and status codes, entry layout
// no dependencies
`timescale 1ns / 1ps

package sas_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int MAX_SCOPES_DEF  = 16;
	localparam int ATTR_KINDS      = 32;
	localparam int KIND_W          = $clog2(ATTR_KINDS);
	localparam int VALUE_W         = 16;

	localparam logic signed [VALUE_W-1:0] VALUE_NONE = {VALUE_W{1'b1}};

	typedef enum logic [2:0] {
		REQ_OPEN   = 3'd0,
		REQ_PUSH   = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_CLOSE  = 3'd3,
		REQ_EMPTY  = 3'd4,
		REQ_LOOKUP = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSCOPE = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		req_type_t                  req_type;
		logic [KIND_W-1:0]          attr_kind;
		logic signed [VALUE_W-1:0]  attr_value;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic                       found;
		logic signed [VALUE_W-1:0]  value;
	} rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic signed [VALUE_W-1:0]  value;
	} entry_t;

endpackage

// ----- sv/sas_store.sv -----
// entry store of the scoped attribute stack: one write port, one read port
// with registered read data
// depends on sas_pkg
`timescale 1ns / 1ps

module sas_store #(
	parameter int DEPTH = sas_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  sas_pkg::entry_t            wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output sas_pkg::entry_t            rd_data
);
	import sas_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- sv/scoped_attribute_stack_unit.sv -----
// top level of the scoped attribute stack: request sequencer, scope start
// memory and result register
// depends on sas_pkg and sas_store
`timescale 1ns / 1ps

// Nested scopes of (kind, value) entries kept in one shared store, scopes laid
// out back to back. One request is taken at a time and gives one response.
// Open, push, empty, the unused codes, any refused request and a close of the
// last scope go from execution straight to the done step. A close with a scope
// below it takes an extra step that reads the start of that scope from the
// scope start memory. Lookup and remove walk the entry store from the newest
// entry down, one entry per cycle through the store's single read port: all
// entries for a lookup, the top scope for a remove. A remove that hits then
// compacts the entries above the hit, one per cycle. The store and the scope
// memory need no clearing after reset. A finished response waits in the
// output register while the next request is already accepted.

module scoped_attribute_stack_unit #(
	parameter int MAX_ENTRIES = sas_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_SCOPES  = sas_pkg::MAX_SCOPES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sas_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sas_pkg::rsp_t  rsp
);
	import sas_pkg::*;

	localparam int IW  = $clog2(MAX_ENTRIES);     // entry address
	localparam int CW  = $clog2(MAX_ENTRIES + 1); // entry count
	localparam int SIW = $clog2(MAX_SCOPES);      // scope address
	localparam int SCW = $clog2(MAX_SCOPES + 1);  // scope count

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_BASE  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t          state_q;
	req_t            req_q;
	logic [SCW-1:0]  scope_cnt_q;
	logic [CW-1:0]   entry_cnt_q;
	logic [CW-1:0]   base_q;      // first entry of the top scope
	logic [IW-1:0]   ptr_q;       // next entry to read while scanning
	logic [CW-1:0]   left_q;      // entries still to read while scanning
	logic [CW-1:0]   sp_q;        // next entry to read while compacting
	logic            rd_vld_s1;   // store read data valid this cycle
	logic [IW-1:0]   rd_idx_s1;   // address of that read
	rsp_t            res_q;       // response under construction
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	// scope start memory
	logic [CW-1:0]   ss_mem [MAX_SCOPES];
	logic [CW-1:0]   ss_rd_q;
	logic            ss_wr_en;
	logic            ss_rd_en;
	logic [SCW-1:0]  scope_cnt_m2;

	// entry store port
	logic            st_wr_en;
	logic [IW-1:0]   st_wr_addr;
	entry_t          st_wr_data;
	logic            st_rd_en;
	logic [IW-1:0]   st_rd_addr;
	entry_t          st_rd_data;

	logic            no_scope;
	logic            scopes_full;
	logic            store_full;
	logic            top_empty;
	logic            hit;
	logic            scan_issue;
	logic            shift_issue;
	logic            rsp_free;

	sas_store #(
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	assign no_scope     = (scope_cnt_q == '0);
	assign scopes_full  = (scope_cnt_q >= SCW'(MAX_SCOPES));
	assign store_full   = (entry_cnt_q >= CW'(MAX_ENTRIES));
	assign top_empty    = (entry_cnt_q <= base_q);
	assign scope_cnt_m2 = scope_cnt_q - SCW'(2);

	// the compare of the scan: read data against the requested kind
	assign hit         = rd_vld_s1 && (st_rd_data.kind == req_q.attr_kind);
	assign scan_issue  = !hit && (left_q != '0);
	assign shift_issue = (sp_q != entry_cnt_q);
	assign rsp_free    = !rsp_valid_q || !rsp_stall;

	// memory port control
	always_comb begin
		st_wr_en   = 1'b0;
		st_wr_addr = entry_cnt_q[IW-1:0];
		st_wr_data = '{kind: req_q.attr_kind, value: req_q.attr_value};
		st_rd_en   = 1'b0;
		st_rd_addr = ptr_q;
		ss_wr_en   = 1'b0;
		ss_rd_en   = 1'b0;
		case (state_q)
			S_EXEC: begin
				case (req_q.req_type)
					REQ_OPEN:  ss_wr_en = !scopes_full;
					REQ_PUSH:  st_wr_en = !no_scope && !store_full;
					REQ_CLOSE: ss_rd_en = (scope_cnt_q > SCW'(1));
					default:   ;
				endcase
			end
			S_SCAN: begin
				st_rd_en = scan_issue;
			end
			S_SHIFT: begin
				// read entry sp, then write it one slot lower in the cycle after
				st_rd_en   = shift_issue;
				st_rd_addr = sp_q[IW-1:0];
				st_wr_en   = rd_vld_s1;
				st_wr_addr = rd_idx_s1 - IW'(1);
				st_wr_data = st_rd_data;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ss_wr_en) begin
			ss_mem[scope_cnt_q[SIW-1:0]] <= entry_cnt_q;
		end
		if (ss_rd_en) begin
			ss_rd_q <= ss_mem[scope_cnt_m2[SIW-1:0]];
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scope_cnt_q <= '0;
			entry_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q   <= '{status: ST_OK, found: 1'b0, value: '0};
					state_q <= S_DONE;
					case (req_q.req_type)
						REQ_OPEN: begin
							if (scopes_full) begin
								res_q.status <= ST_FULL;
							end else begin
								base_q      <= entry_cnt_q;
								scope_cnt_q <= scope_cnt_q + SCW'(1);
							end
						end
						REQ_PUSH: begin
							if (no_scope) begin
								res_q.status <= ST_NOSCOPE;
							end else if (store_full) begin
								res_q.status <= ST_FULL;
							end else begin
								entry_cnt_q <= entry_cnt_q + CW'(1);
							end
						end
						REQ_REMOVE: begin
							if (no_scope) begin
								res_q.status <= ST_NOSCOPE;
							end else if (top_empty) begin
								res_q.status <= ST_EMPTY;
							end else begin
								// found reports a non-empty top scope, hit or not
								res_q.found <= 1'b1;
								ptr_q       <= IW'(entry_cnt_q - CW'(1));
								left_q      <= entry_cnt_q - base_q;
								state_q     <= S_SCAN;
							end
						end
						REQ_CLOSE: begin
							if (no_scope) begin
								res_q.status <= ST_NOSCOPE;
							end else begin
								entry_cnt_q <= base_q;
								scope_cnt_q <= scope_cnt_q - SCW'(1);
								if (scope_cnt_q > SCW'(1)) begin
									state_q <= S_BASE;
								end
							end
						end
						REQ_EMPTY: begin
							if (no_scope) begin
								res_q.status <= ST_NOSCOPE;
							end else begin
								entry_cnt_q <= base_q;
							end
						end
						REQ_LOOKUP: begin
							res_q.value <= VALUE_NONE;
							if (no_scope) begin
								res_q.status <= ST_NOSCOPE;
							end else if (entry_cnt_q != '0) begin
								ptr_q   <= IW'(entry_cnt_q - CW'(1));
								left_q  <= entry_cnt_q;
								state_q <= S_SCAN;
							end
						end
						default: ;
					endcase
				end
				S_SCAN: begin
					if (hit) begin
						if (req_q.req_type == REQ_LOOKUP) begin
							res_q.found <= 1'b1;
							res_q.value <= st_rd_data.value;
							state_q     <= S_DONE;
						end else begin
							sp_q    <= CW'(rd_idx_s1) + CW'(1);
							state_q <= S_SHIFT;
						end
					end else if (scan_issue) begin
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= ptr_q;
						ptr_q     <= ptr_q - IW'(1);
						left_q    <= left_q - CW'(1);
					end else if (!rd_vld_s1) begin
						// walked the whole range without a match
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (shift_issue) begin
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= sp_q[IW-1:0];
						sp_q      <= sp_q + CW'(1);
					end else if (!rd_vld_s1) begin
						entry_cnt_q <= entry_cnt_q - CW'(1);
						state_q     <= S_DONE;
					end
				end
				S_BASE: begin
					base_q  <= ss_rd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the top scope never starts above the fill level
	a_base_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(scope_cnt_q != '0) |-> (base_q <= entry_cnt_q))
		else $error("top scope start above entry count");

	// scope count moves only while a request executes
	a_scope_cnt_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(scope_cnt_q != $past(scope_cnt_q)) |-> ($past(state_q) == S_EXEC))
		else $error("scope count changed outside execution");

	// a response appears only out of the done step
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("response raised outside done step");

	// an accepted request goes straight to execution
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_EXEC))
		else $error("accepted request did not start");

	// compaction only ever writes below the entry it reads next
	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && st_wr_en) |-> (CW'(st_wr_addr) < sp_q))
		else $error("compaction write overtook its read");

endmodule
